@@ rtl/urp_pkg.sv @@
// Package for the UART status record parser.
// Holds sizes, ident and phase codes, record kinds, the control struct and decode functions.
// No dependencies.
package urp_pkg;

	localparam int PORT_COUNT = 8;
	localparam int COUNT_BITS = 32;
	localparam int PORT_IDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

	localparam logic [7:0] ID_INIT     = 8'hA1;
	localparam logic [7:0] ID_VEN_READ = 8'h85;
	localparam logic [3:0] ID_LOW_LSR  = 4'h6;
	localparam logic [3:0] ID_LOW_TXE  = 4'h2;
	localparam logic [3:0] INIT_LEN    = 4'd10;
	localparam logic [3:0] VEN_LEN     = 4'd2;
	localparam logic [3:0] OTHER_LEN   = 4'd1;

	// Parser phase codes
	localparam logic [2:0] PH_FIRST_PORT  = 3'd0;
	localparam logic [2:0] PH_FIRST_IDENT = 3'd1;
	localparam logic [2:0] PH_PORT        = 3'd2;
	localparam logic [2:0] PH_IDENT       = 3'd3;
	localparam logic [2:0] PH_PAYLOAD     = 3'd4;
	localparam logic [2:0] PH_SKIP        = 3'd5;

	// Record kinds
	localparam logic [2:0] KIND_INIT     = 3'd0;
	localparam logic [2:0] KIND_VEN_READ = 3'd1;
	localparam logic [2:0] KIND_LSR      = 3'd2;
	localparam logic [2:0] KIND_TX_EMPTY = 3'd3;
	localparam logic [2:0] KIND_OTHER    = 3'd4;
	localparam logic [2:0] KIND_UNSUP    = 3'd5;
	localparam logic [2:0] KIND_BADPORT  = 3'd6;
	localparam logic [2:0] KIND_TRUNC    = 3'd7;

	// Counter slots in the bump vector and totals
	localparam int CNT_OVERRUN = 0;
	localparam int CNT_PARITY  = 1;
	localparam int CNT_FRAMING = 2;
	localparam int CNT_BREAK   = 3;
	localparam int NUM_CNT     = 4;

	typedef struct packed {
		logic                emit;
		logic [3:0]          port;
		logic [2:0]          kind;
		logic [7:0]          lsr;
		logic [NUM_CNT-1:0]  bump;
	} rec_ctl_t;

	typedef logic [NUM_CNT-1:0][COUNT_BITS-1:0] totals_t;

	function automatic logic [2:0] kind_of(input logic [7:0] id);
		logic [2:0] k;
		if (id == ID_INIT) begin
			k = KIND_INIT;
		end else if (id == ID_VEN_READ) begin
			k = KIND_VEN_READ;
		end else if (id[3:0] == 4'h0) begin
			k = KIND_UNSUP;
		end else if (id[3:0] == ID_LOW_LSR) begin
			k = KIND_LSR;
		end else if (id[3:0] == ID_LOW_TXE) begin
			k = KIND_TX_EMPTY;
		end else begin
			k = KIND_OTHER;
		end
		return k;
	endfunction

	function automatic logic [3:0] payload_len(input logic [7:0] id);
		logic [3:0] n;
		if (id == ID_INIT) begin
			n = INIT_LEN;
		end else if (id == ID_VEN_READ) begin
			n = VEN_LEN;
		end else begin
			n = OTHER_LEN;
		end
		return n;
	endfunction

	function automatic logic port_ok(input logic [3:0] p);
		return (int'(p) < PORT_COUNT);
	endfunction

endpackage

@@ rtl/urp_parse.sv @@
// Record parser state machine for the UART status record parser.
// Decodes one buffered byte per cycle, while advance is high, into a record control struct.
// Depends on urp_pkg.
module urp_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [7:0]        status_byte,
	input  logic              last_of_buffer,
	output urp_pkg::rec_ctl_t ctl
);

	logic [2:0] phase_q, phase_n;
	logic [3:0] port_q, port_n;
	logic [7:0] ident_q, ident_n;
	logic [3:0] left_q, left_n;
	logic [7:0] first_q, first_n;
	logic [7:0] cur_first;
	logic [3:0] left_dec;
	logic [2:0] pay_kind;

	always_comb begin
		phase_n   = phase_q;
		port_n    = port_q;
		ident_n   = ident_q;
		left_n    = left_q;
		first_n   = first_q;
		ctl       = '0;
		ctl.port  = port_q;
		cur_first = (left_q == urp_pkg::payload_len(ident_q)) ? status_byte : first_q;
		left_dec  = (left_q != 4'd0) ? left_q - 4'd1 : 4'd0;
		pay_kind  = urp_pkg::kind_of(ident_q);
		case (phase_q)
			urp_pkg::PH_FIRST_IDENT, urp_pkg::PH_IDENT: begin
				ident_n = status_byte;
				if (phase_q == urp_pkg::PH_FIRST_IDENT && last_of_buffer) begin
					phase_n = urp_pkg::PH_FIRST_PORT;
				end else if (!urp_pkg::port_ok(port_q)) begin
					ctl.emit = 1'b1;
					ctl.kind = urp_pkg::KIND_BADPORT;
					phase_n  = last_of_buffer ? urp_pkg::PH_FIRST_PORT : urp_pkg::PH_SKIP;
				end else if (last_of_buffer) begin
					ctl.emit = 1'b1;
					ctl.kind = urp_pkg::KIND_TRUNC;
					phase_n  = urp_pkg::PH_FIRST_PORT;
				end else begin
					left_n  = urp_pkg::payload_len(status_byte);
					first_n = 8'h00;
					phase_n = urp_pkg::PH_PAYLOAD;
				end
			end
			urp_pkg::PH_SKIP: begin
				phase_n = last_of_buffer ? urp_pkg::PH_FIRST_PORT : urp_pkg::PH_SKIP;
			end
			urp_pkg::PH_PAYLOAD: begin
				first_n = cur_first;
				left_n  = left_dec;
				if (left_dec != 4'd0) begin
					if (last_of_buffer) begin
						ctl.emit = 1'b1;
						ctl.kind = urp_pkg::KIND_TRUNC;
						phase_n  = urp_pkg::PH_FIRST_PORT;
					end
				end else begin
					ctl.emit = 1'b1;
					ctl.kind = pay_kind;
					ctl.lsr  = cur_first;
					if (pay_kind == urp_pkg::KIND_LSR && urp_pkg::port_ok(port_q)) begin
						ctl.bump[urp_pkg::CNT_OVERRUN] = cur_first[1];
						ctl.bump[urp_pkg::CNT_PARITY]  = cur_first[2];
						ctl.bump[urp_pkg::CNT_FRAMING] = cur_first[3];
						ctl.bump[urp_pkg::CNT_BREAK]   = cur_first[4];
					end
					phase_n = last_of_buffer ? urp_pkg::PH_FIRST_PORT : urp_pkg::PH_PORT;
				end
			end
			default: begin
				// port byte; unused codes count as the start of a buffer
				port_n = status_byte[3:0];
				if (last_of_buffer) begin
					phase_n = urp_pkg::PH_FIRST_PORT;
				end else if (phase_q == urp_pkg::PH_PORT) begin
					phase_n = urp_pkg::PH_IDENT;
				end else begin
					phase_n = urp_pkg::PH_FIRST_IDENT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= urp_pkg::PH_FIRST_PORT;
			port_q  <= '0;
			ident_q <= '0;
			left_q  <= '0;
			first_q <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			port_q  <= port_n;
			ident_q <= ident_n;
			left_q  <= left_n;
			first_q <= first_n;
		end
	end

endmodule

@@ rtl/urp_counters.sv @@
// Per-port line error counter bank for the UART status record parser.
// Read-modify-write of the record's port; totals show the post-update values.
// Depends on urp_pkg.
module urp_counters (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              commit,
	input  urp_pkg::rec_ctl_t ctl,
	output urp_pkg::totals_t  totals
);

	urp_pkg::totals_t              cnt_q [urp_pkg::PORT_COUNT];
	logic [urp_pkg::PORT_IDX_W-1:0] idx;
	logic                           in_range;

	assign idx      = ctl.port[urp_pkg::PORT_IDX_W-1:0];
	assign in_range = urp_pkg::port_ok(ctl.port);

	always_comb begin
		for (int k = 0; k < urp_pkg::NUM_CNT; k++) begin
			if (in_range) begin
				totals[k] = cnt_q[idx][k]
					+ {{(urp_pkg::COUNT_BITS-1){1'b0}}, ctl.bump[k]};
			end else begin
				totals[k] = '0;
			end
		end
	end

	for (genvar i = 0; i < urp_pkg::PORT_COUNT; i++) begin : g_port
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cnt_q[i] <= '0;
			end else if (commit && ctl.emit && in_range
				&& idx == urp_pkg::PORT_IDX_W'(i)) begin
				cnt_q[i] <= totals;
			end
		end
	end

endmodule

@@ rtl/uart_status_record_parser.sv @@
// UART status record parser, top level.
// Path: an accepted byte is held in the input register and parsed from there; its
// record, if any, is loaded into the result register that drives record_valid.
// Throughput: one status byte per cycle; a byte that makes a record waits while the result
// register is held by record_stall.
// Reset (arst_n low, asynchronous): parser expects a buffer's first port byte, all
// per-port counters read zero, both pipeline valids clear. Depends on urp_pkg.
module uart_status_record_parser (
	input  logic        clk,
	input  logic        arst_n,
	// status byte channel
	input  logic        status_valid,
	output logic        status_stall,
	input  logic [7:0]  status_byte,
	input  logic        last_of_buffer,
	// record channel
	output logic        record_valid,
	input  logic        record_stall,
	output logic [3:0]  port_index,
	output logic [2:0]  record_kind,
	output logic [7:0]  line_status,
	output logic [31:0] overrun_total,
	output logic [31:0] parity_total,
	output logic [31:0] framing_total,
	output logic [31:0] break_total
);

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Result register
	logic                  valid_s2;
	logic [3:0]            port_s2;
	logic [2:0]            kind_s2;
	logic [7:0]            lsr_s2;
	urp_pkg::totals_t      totals_s2;

	urp_pkg::rec_ctl_t ctl;
	urp_pkg::totals_t  totals;
	logic              out_free;
	logic              fire;
	logic              take_in;

	// The result slot is free if empty or being drained this cycle.
	assign out_free = !valid_s2 || !record_stall;
	// Process the held byte unless it makes a record and the slot is busy.
	assign fire     = valid_s1 && (!ctl.emit || out_free);
	assign status_stall = valid_s1 && !fire;
	assign take_in  = status_valid && !status_stall;

	urp_parse u_parse (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (fire),
		.status_byte    (byte_s1),
		.last_of_buffer (last_s1),
		.ctl            (ctl)
	);

	urp_counters u_counters (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (fire),
		.ctl    (ctl),
		.totals (totals)
	);

	// Input stage: load on each accepted transaction, drop once processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= status_byte;
			last_s1 <= last_of_buffer;
		end
	end

	// Result stage: hold while stalled, advance when a record is produced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire && ctl.emit) begin
			valid_s2 <= 1'b1;
		end else if (!record_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && ctl.emit) begin
			port_s2   <= ctl.port;
			kind_s2   <= ctl.kind;
			lsr_s2    <= ctl.lsr;
			totals_s2 <= totals;
		end
	end

	assign record_valid  = valid_s2;
	assign port_index    = port_s2;
	assign record_kind   = kind_s2;
	assign line_status   = lsr_s2;
	assign overrun_total = 32'(totals_s2[urp_pkg::CNT_OVERRUN]);
	assign parity_total  = 32'(totals_s2[urp_pkg::CNT_PARITY]);
	assign framing_total = 32'(totals_s2[urp_pkg::CNT_FRAMING]);
	assign break_total   = 32'(totals_s2[urp_pkg::CNT_BREAK]);

endmodule

@@ verif/uart_status_record_parser_tb.sv @@
// Self-checking testbench for uart_status_record_parser.
// Drives status buffers and checks every record against a cycle-free parser model.
// Depends on urp_pkg and the uart_status_record_parser RTL.
module uart_status_record_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles with no transaction on either channel before the run is abandoned
	localparam int QUIET_LIMIT = 2000;

	typedef logic [7:0] byte_q_t[$];

	// One record as the block should report it
	typedef struct {
		logic [3:0]  port;
		logic [2:0]  kind;
		logic [7:0]  lsr;
		logic [31:0] overrun;
		logic [31:0] parity;
		logic [31:0] framing;
		logic [31:0] brk;
	} record_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        status_valid = 1'b0;
	logic        status_stall;
	logic [7:0]  status_byte = 8'h00;
	logic        last_of_buffer = 1'b0;
	logic        record_valid;
	logic        record_stall = 1'b0;
	logic [3:0]  port_index;
	logic [2:0]  record_kind;
	logic [7:0]  line_status;
	logic [31:0] overrun_total;
	logic [31:0] parity_total;
	logic [31:0] framing_total;
	logic [31:0] break_total;

	// Parser state mirrored by the testbench
	logic [2:0]                     parse_ph = urp_pkg::PH_FIRST_PORT;
	logic [3:0]                     cur_port = '0;
	logic [7:0]                     cur_ident = '0;
	logic [3:0]                     bytes_left = '0;
	logic [7:0]                     first_byte = '0;
	logic [urp_pkg::COUNT_BITS-1:0] overrun_cnt [urp_pkg::PORT_COUNT] = '{default: '0};
	logic [urp_pkg::COUNT_BITS-1:0] parity_cnt  [urp_pkg::PORT_COUNT] = '{default: '0};
	logic [urp_pkg::COUNT_BITS-1:0] framing_cnt [urp_pkg::PORT_COUNT] = '{default: '0};
	logic [urp_pkg::COUNT_BITS-1:0] break_cnt   [urp_pkg::PORT_COUNT] = '{default: '0};

	record_t pending_records[$];
	byte_q_t build_q;
	int      gap_pct = 19;
	int      stall_pct = 19;
	int      items_sent = 0;
	int      mismatches = 0;
	int      quiet_cycles = 0;

	uart_status_record_parser i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.status_valid  (status_valid),
		.status_stall  (status_stall),
		.status_byte   (status_byte),
		.last_of_buffer(last_of_buffer),
		.record_valid  (record_valid),
		.record_stall  (record_stall),
		.port_index    (port_index),
		.record_kind   (record_kind),
		.line_status   (line_status),
		.overrun_total (overrun_total),
		.parity_total  (parity_total),
		.framing_total (framing_total),
		.break_total   (break_total)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------

	function automatic logic [2:0] kind_for_ident(input logic [7:0] id);
		case (id)
			urp_pkg::ID_INIT:     return urp_pkg::KIND_INIT;
			urp_pkg::ID_VEN_READ: return urp_pkg::KIND_VEN_READ;
			default: begin
				// A zero low nibble wins over the line-status and tx-empty codes
				case (id[3:0])
					4'h0:                return urp_pkg::KIND_UNSUP;
					urp_pkg::ID_LOW_LSR: return urp_pkg::KIND_LSR;
					urp_pkg::ID_LOW_TXE: return urp_pkg::KIND_TX_EMPTY;
					default:             return urp_pkg::KIND_OTHER;
				endcase
			end
		endcase
	endfunction

	function automatic logic [3:0] payload_bytes(input logic [7:0] id);
		case (id)
			urp_pkg::ID_INIT:     return urp_pkg::INIT_LEN;
			urp_pkg::ID_VEN_READ: return urp_pkg::VEN_LEN;
			default:              return urp_pkg::OTHER_LEN;
		endcase
	endfunction

	// Queue a record with the port's totals as they stand now; ports out of range read zero
	function automatic void expect_record(input logic [3:0] p, input logic [2:0] k,
			input logic [7:0] lsr);
		record_t r;
		r.port = p;
		r.kind = k;
		r.lsr  = lsr;
		if (int'(p) < urp_pkg::PORT_COUNT) begin
			r.overrun = 32'(overrun_cnt[p]);
			r.parity  = 32'(parity_cnt[p]);
			r.framing = 32'(framing_cnt[p]);
			r.brk     = 32'(break_cnt[p]);
		end else begin
			r.overrun = '0;
			r.parity  = '0;
			r.framing = '0;
			r.brk     = '0;
		end
		pending_records.push_back(r);
	endfunction

	// Advance the model by one accepted status byte
	function automatic void advance_parser(input logic [7:0] b, input logic is_last);
		case (parse_ph)
			urp_pkg::PH_FIRST_IDENT, urp_pkg::PH_IDENT: begin
				cur_ident = b;
				if (parse_ph == urp_pkg::PH_FIRST_IDENT && is_last) begin
					// Two-byte buffer: nothing to report
					parse_ph = urp_pkg::PH_FIRST_PORT;
				end else if (int'(cur_port) >= urp_pkg::PORT_COUNT) begin
					expect_record(cur_port, urp_pkg::KIND_BADPORT, 8'h00);
					parse_ph = is_last ? urp_pkg::PH_FIRST_PORT : urp_pkg::PH_SKIP;
				end else if (is_last) begin
					expect_record(cur_port, urp_pkg::KIND_TRUNC, 8'h00);
					parse_ph = urp_pkg::PH_FIRST_PORT;
				end else begin
					bytes_left = payload_bytes(b);
					first_byte = 8'h00;
					parse_ph   = urp_pkg::PH_PAYLOAD;
				end
			end
			urp_pkg::PH_SKIP: begin
				parse_ph = is_last ? urp_pkg::PH_FIRST_PORT : urp_pkg::PH_SKIP;
			end
			urp_pkg::PH_PAYLOAD: begin
				if (bytes_left == payload_bytes(cur_ident)) begin
					first_byte = b;
				end
				if (bytes_left != 0) begin
					bytes_left = bytes_left - 1'b1;
				end
				if (bytes_left != 0) begin
					if (is_last) begin
						expect_record(cur_port, urp_pkg::KIND_TRUNC, 8'h00);
						parse_ph = urp_pkg::PH_FIRST_PORT;
					end
				end else begin
					if (kind_for_ident(cur_ident) == urp_pkg::KIND_LSR
						&& int'(cur_port) < urp_pkg::PORT_COUNT) begin
						// Bits 1..4 of the line status: overrun, parity, framing, break
						if (first_byte[1]) overrun_cnt[cur_port] = overrun_cnt[cur_port] + 1'b1;
						if (first_byte[2]) parity_cnt[cur_port]  = parity_cnt[cur_port] + 1'b1;
						if (first_byte[3]) framing_cnt[cur_port] = framing_cnt[cur_port] + 1'b1;
						if (first_byte[4]) break_cnt[cur_port]   = break_cnt[cur_port] + 1'b1;
					end
					expect_record(cur_port, kind_for_ident(cur_ident), first_byte);
					parse_ph = is_last ? urp_pkg::PH_FIRST_PORT : urp_pkg::PH_PORT;
				end
			end
			default: begin
				// Port byte; a port byte closing its buffer is dropped
				cur_port = b[3:0];
				if (is_last) begin
					parse_ph = urp_pkg::PH_FIRST_PORT;
				end else begin
					parse_ph = (parse_ph == urp_pkg::PH_PORT) ? urp_pkg::PH_IDENT
						: urp_pkg::PH_FIRST_IDENT;
				end
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Status byte channel
	// ------------------------------------------------------------------

	// Offer one byte, idling first at random; hold the payload until the block takes it
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		if ($urandom_range(99) < gap_pct) begin
			status_valid <= 1'b0;
			@(posedge clk);
		end
		status_valid   <= 1'b1;
		status_byte    <= b;
		last_of_buffer <= is_last;
		do @(posedge clk); while (status_stall);
		advance_parser(b, is_last);
		items_sent++;
	endtask

	task automatic send_buffer(input byte_q_t bytes_in);
		foreach (bytes_in[i]) begin
			send_byte(bytes_in[i], i == bytes_in.size() - 1);
		end
	endtask

	// Drop valid and hold off until every expected record has come back
	task automatic wait_drained();
		status_valid <= 1'b0;
		do @(posedge clk); while (pending_records.size() != 0);
	endtask

	// Append one well-formed record with random content to build_q
	function automatic void append_record();
		logic [7:0] id;
		logic [3:0] p;
		int         n;
		p = 4'($urandom_range(urp_pkg::PORT_COUNT - 1));
		if (urp_pkg::PORT_COUNT < 16 && $urandom_range(99) < 8) begin
			p = 4'($urandom_range(15, urp_pkg::PORT_COUNT));
		end
		// The high nibble of the port byte is don't-care
		build_q.push_back({4'($urandom), p});
		case ($urandom_range(5))
			0:       id = urp_pkg::ID_INIT;
			1:       id = urp_pkg::ID_VEN_READ;
			2:       id = {4'($urandom), urp_pkg::ID_LOW_LSR};
			3:       id = {4'($urandom), urp_pkg::ID_LOW_TXE};
			4:       id = {4'($urandom), 4'h0};
			default: id = 8'($urandom);
		endcase
		build_q.push_back(id);
		n = int'(payload_bytes(id));
		repeat (n) build_q.push_back(8'($urandom));
	endfunction

	// Mostly well-formed buffers, some cut short, a few pure noise
	task automatic send_random_buffer();
		int pick;
		int cut;
		build_q = {};
		pick = $urandom_range(99);
		if (pick < 6) begin
			repeat ($urandom_range(1, 8)) build_q.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(1, 4)) append_record();
			if (pick < 22) begin
				cut = $urandom_range(build_q.size() - 1, 1);
				while (build_q.size() > cut) void'(build_q.pop_back());
			end
		end
		send_buffer(build_q);
	endtask

	// ------------------------------------------------------------------
	// Record channel: compare each transaction with the oldest expectation
	// ------------------------------------------------------------------

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		record_t want;
		if (record_valid && !record_stall) begin
			if (pending_records.size() == 0) begin
				$error("unexpected record: port %0h kind %0h", port_index, record_kind);
				mismatches++;
			end else begin
				want = pending_records.pop_front();
				check_field("port_index", 32'(want.port), 32'(port_index));
				check_field("record_kind", 32'(want.kind), 32'(record_kind));
				check_field("line_status", 32'(want.lsr), 32'(line_status));
				check_field("overrun_total", want.overrun, overrun_total);
				check_field("parity_total", want.parity, parity_total);
				check_field("framing_total", want.framing, framing_total);
				check_field("break_total", want.brk, break_total);
			end
		end
		record_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	// Abort when neither channel moves for too long
	always @(posedge clk) begin
		if ((status_valid && !status_stall) || (record_valid && !record_stall)) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// One-byte and two-byte buffers report nothing
	task automatic test_short_buffers();
		send_buffer({8'h0f});
		send_buffer({8'h08, 8'h06});
	endtask

	// Each kind of a whole record on a valid port, with the all-ones and all-zero bytes and a full LSR bump
	task automatic test_record_kinds();
		send_buffer({8'h00, urp_pkg::ID_INIT, 8'hff, 8'h00, 8'h55, 8'haa, 8'h01, 8'h02,
			8'h04, 8'h08, 8'h10, 8'h80});
		send_buffer({8'h87, urp_pkg::ID_VEN_READ, 8'h12, 8'h34,
			8'h03, 8'h06, 8'h1e,
			8'hf2, 8'h02, 8'h00,
			8'h04, 8'hff, 8'h80,
			8'h05, 8'hf0, 8'h55});
	endtask

	// A port of 8 or more reports once, then the rest of the buffer is skipped
	task automatic test_bad_port();
		send_buffer({8'h08, urp_pkg::ID_INIT, 8'hff, 8'h00});
	endtask

	// Buffer ends on a later record's ident, then inside a payload
	task automatic test_truncation();
		send_buffer({8'h01, 8'h06, 8'h02, 8'h01, 8'h06});
		send_buffer({8'h02, urp_pkg::ID_VEN_READ, 8'h11});
	endtask

	task automatic test_random_buffers(input int target);
		while (items_sent < target) send_random_buffer();
	endtask

	// Full rate on both sides, no idling at all
	task automatic test_back_to_back(input int count);
		int stop_at;
		stop_at   = items_sent + count;
		gap_pct   = 0;
		stall_pct = 0;
		while (items_sent < stop_at) send_random_buffer();
		gap_pct   = 19;
		stall_pct = 19;
	endtask

	// Let the pipeline run dry between buffers
	task automatic test_drain_pause(input int buffers);
		repeat (buffers) begin
			send_random_buffer();
			wait_drained();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_buffers();
		test_record_kinds();
		test_bad_port();
		test_truncation();
		test_random_buffers(600);
		test_back_to_back(250);
		test_drain_pause(6);
		test_random_buffers(1100);
		wait_drained();
		// Leave room for any stray record to show up
		repeat (4) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/urp_pkg.sv
rtl/urp_parse.sv
rtl/urp_counters.sv
rtl/uart_status_record_parser.sv
verif/uart_status_record_parser_tb.sv
